@@ hdl/cti_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cti_pkg
// Shared types and constants of the color threshold inner edge block.
// ----------------------------------------------------------------------------
package cti_pkg;

  localparam int CTI_MAX_LINE_WIDTH = 1024;
  localparam int CTI_KERNEL_REACH   = 2;

  localparam int CHAN_W        = 8;
  localparam int LINE_WIDTH_W  = 11;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 11;
  localparam int MIN_LINE_WIDTH = 5;

  localparam logic [CHAN_W-1:0]       LOW_RESET        = 8'd0;
  localparam logic [CHAN_W-1:0]       HIGH_RESET       = 8'd255;
  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 11'd640;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLUE_LOW   = 3'd0,
    CFG_BLUE_HIGH  = 3'd1,
    CFG_GREEN_LOW  = 3'd2,
    CFG_GREEN_HIGH = 3'd3,
    CFG_RED_LOW    = 3'd4,
    CFG_RED_HIGH   = 3'd5,
    CFG_LINE_WIDTH = 3'd6
  } cti_cfg_idx_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue_value;
    logic [CHAN_W-1:0] green_value;
    logic [CHAN_W-1:0] red_value;
    logic              frame_start;
    logic              is_pixel;
  } cti_in_t;

  typedef struct packed {
    logic edge_res;
    logic row_end;
    logic run_last;
  } cti_out_t;

  // Load request from the window stage to the result queue.
  typedef struct packed {
    logic valid;   // a set of results is handed over
    logic multi;   // row end: the full tail of the row, else one result
  } cti_load_t;

endpackage : cti_pkg
`default_nettype wire

@@ hdl/color_threshold_inner_edge.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// color_threshold_inner_edge
// Color threshold mask followed by the inner boundary of a cross erosion.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order, one per transaction, and each becomes a mask
// bit when blue, green and red all lie inside their configured bounds. The
// block erodes the mask with a cross of KERNEL_REACH pixels each way and emits
// mask AND NOT eroded, lagging KERNEL_REACH rows and columns. Pixels are taken
// at a sustained rate of one per clock while out_ready is high; the last
// pixel of a row emits KERNEL_REACH+1 results, one per cycle on the result
// port while out_ready is high, and holds input until the last is taken.
// Each pixel reads and writes one entry of the line memory (one read port, one
// write port, registered read). After reset a pass clears the line memory and
// no pixel is taken until it ends; configuration writes are taken at any time.
// Send KERNEL_REACH padding rows (is_pixel low) to flush a frame. The width
// register is clamped to [5, MAX_LINE_WIDTH] and latched at each row start.
// ----------------------------------------------------------------------------
module color_threshold_inner_edge #(
  parameter int MAX_LINE_WIDTH = cti_pkg::CTI_MAX_LINE_WIDTH,
  parameter int KERNEL_REACH   = cti_pkg::CTI_KERNEL_REACH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire cti_pkg::cti_in_t               in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output cti_pkg::cti_out_t                   out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cti_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cti_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cti_pkg::*;

  localparam int WIN  = 2 * KERNEL_REACH + 1;
  localparam int LD   = 2 * KERNEL_REACH;
  localparam int AW   = $clog2(MAX_LINE_WIDTH);
  localparam int RWW  = $clog2(MAX_LINE_WIDTH + 1);
  localparam int CMPW = (RWW > LINE_WIDTH_W) ? RWW : LINE_WIDTH_W;

  // Configuration registers
  logic [CHAN_W-1:0]       blue_low_r, blue_high_r;
  logic [CHAN_W-1:0]       green_low_r, green_high_r;
  logic [CHAN_W-1:0]       red_low_r, red_high_r;
  logic [LINE_WIDTH_W-1:0] line_width_r;

  // Row tracking state
  logic [AW-1:0]  col_r;
  logic [LD-1:0]  flags_r;
  logic [RWW-1:0] width_r;
  logic           image_r;

  // Memory clearing pass
  logic          clr_active_r;
  logic [AW-1:0] clr_addr_r;

  // Line memory: per column the mask bits of the previous LD rows
  logic [LD-1:0] line_mem [MAX_LINE_WIDTH];
  logic [LD-1:0] mem_rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [LD-1:0] mem_wdata;

  // Window stage registers
  logic          b_valid_r;
  logic [AW-1:0] b_col_r;
  logic          b_cur_r;
  logic          b_last_r;
  logic          b_image_r;
  logic [LD-1:0] b_flags_r;
  logic          b_fwd_r;
  logic [LD-1:0] b_fwd_data_r;
  logic [WIN-1:0] cwin_r, vwin_r;

  // Accept stage signals
  logic           in_fire, b_fire, q_free;
  logic [AW-1:0]  a_col;
  logic [LD-1:0]  a_flags;
  logic [RWW-1:0] a_width;
  logic           a_image, a_cur, a_last;
  logic [RWW-1:0] a_col_p1;

  // Window stage signals
  logic [LD-1:0]  b_old, b_line_new;
  logic           b_vok, b_centre, b_emit;
  logic [WIN-1:0] cwin_nxt, vwin_nxt;
  logic [KERNEL_REACH:0] b_edges;
  cti_load_t      q_load;

  function automatic logic [RWW-1:0] clamp_width(input logic [LINE_WIDTH_W-1:0] w);
    logic [CMPW-1:0] w_ext;
    w_ext = CMPW'(w);
    if (w_ext < CMPW'(MIN_LINE_WIDTH)) begin
      return RWW'(MIN_LINE_WIDTH);
    end else if (w_ext > CMPW'(MAX_LINE_WIDTH)) begin
      return RWW'(MAX_LINE_WIDTH);
    end
    return RWW'(w_ext);
  endfunction

  // --------------------------------------------------------------------------
  // Configuration: always ready; drop writes beyond the last register.
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blue_low_r   <= LOW_RESET;
      blue_high_r  <= HIGH_RESET;
      green_low_r  <= LOW_RESET;
      green_high_r <= HIGH_RESET;
      red_low_r    <= LOW_RESET;
      red_high_r   <= HIGH_RESET;
      line_width_r <= LINE_WIDTH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BLUE_LOW:   blue_low_r   <= cfg_data[CHAN_W-1:0];
        CFG_BLUE_HIGH:  blue_high_r  <= cfg_data[CHAN_W-1:0];
        CFG_GREEN_LOW:  green_low_r  <= cfg_data[CHAN_W-1:0];
        CFG_GREEN_HIGH: green_high_r <= cfg_data[CHAN_W-1:0];
        CFG_RED_LOW:    red_low_r    <= cfg_data[CHAN_W-1:0];
        CFG_RED_HIGH:   red_high_r   <= cfg_data[CHAN_W-1:0];
        CFG_LINE_WIDTH: line_width_r <= cfg_data[LINE_WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: outside the clearing pass, take a pixel when the window stage is
  // empty or moves this cycle; it moves when the queue can take its results.
  // --------------------------------------------------------------------------
  assign b_fire   = b_valid_r && q_free;
  assign in_ready = !clr_active_r && (!b_valid_r || b_fire);
  assign in_fire  = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // Accept stage: resolve frame start and row start, threshold the pixel,
  // issue the line memory read for this column.
  // --------------------------------------------------------------------------
  always_comb begin
    a_col   = in_data.frame_start ? '0 : col_r;
    a_flags = in_data.frame_start ? '0 : flags_r;
    if (a_col == '0) begin
      a_width = clamp_width(line_width_r);
      a_image = in_data.is_pixel;
    end else begin
      a_width = width_r;
      a_image = image_r;
    end
    a_cur = a_image && in_data.is_pixel &&
            (in_data.blue_value  >= blue_low_r)  && (in_data.blue_value  <= blue_high_r) &&
            (in_data.green_value >= green_low_r) && (in_data.green_value <= green_high_r) &&
            (in_data.red_value   >= red_low_r)   && (in_data.red_value   <= red_high_r);
    a_col_p1 = RWW'(a_col) + RWW'(1);
    a_last   = a_col_p1 >= a_width;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      flags_r <= '0;
      image_r <= 1'b0;
    end else if (in_fire) begin
      image_r <= a_image;
      if (a_last) begin
        col_r   <= '0;
        flags_r <= {a_flags[LD-2:0], a_image};
      end else begin
        col_r   <= a_col + AW'(1);
        flags_r <= a_flags;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      width_r      <= a_width;
      b_col_r      <= a_col;
      b_cur_r      <= a_cur;
      b_last_r     <= a_last;
      b_image_r    <= a_image;
      b_flags_r    <= a_flags;
      // Forward the entry that the window stage writes in this same cycle.
      b_fwd_r      <= b_fire && (b_col_r == a_col);
      b_fwd_data_r <= b_line_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (in_fire) begin
      b_valid_r <= 1'b1;
    end else if (b_fire) begin
      b_valid_r <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Clearing pass after reset: zero one memory entry per cycle.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      if (clr_addr_r == AW'(MAX_LINE_WIDTH - 1)) begin
        clr_active_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Line memory: read at accept; write from the clearing pass or window stage.
  // --------------------------------------------------------------------------
  assign mem_we    = clr_active_r || b_fire;
  assign mem_waddr = clr_active_r ? clr_addr_r : b_col_r;
  assign mem_wdata = clr_active_r ? '0 : b_line_new;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      mem_rdata_r <= line_mem[a_col];
    end
  end

  // --------------------------------------------------------------------------
  // Window stage: vertical AND over valid rows, shift the centre and vertical
  // windows, and form the results of the columns that become complete.
  // --------------------------------------------------------------------------
  always_comb begin
    b_old      = b_fwd_r ? b_fwd_data_r : mem_rdata_r;
    b_vok      = b_image_r ? b_cur_r : 1'b1;
    for (int k = 0; k < LD; k++) begin
      b_vok = b_vok & (!b_flags_r[k] || b_old[k]);
    end
    b_centre   = b_old[KERNEL_REACH-1];
    b_line_new = {b_old[LD-2:0], b_cur_r};
    cwin_nxt   = {b_centre, cwin_r[WIN-1:1]};
    vwin_nxt   = {b_vok, vwin_r[WIN-1:1]};
  end

  // Erosion at each output position; ignore neighbors left of the row start.
  always_comb begin
    logic ok;
    int   pos;
    int   p;
    for (int j = 0; j <= KERNEL_REACH; j++) begin
      pos = KERNEL_REACH + j;
      ok  = vwin_nxt[pos];
      for (int d = 1; d <= KERNEL_REACH; d++) begin
        p = pos - d;
        if (p >= 0 && (int'(b_col_r) + p >= WIN - 1)) begin
          ok = ok & cwin_nxt[p];
        end
        p = pos + d;
        if (p < WIN && (int'(b_col_r) + p >= WIN - 1)) begin
          ok = ok & cwin_nxt[p];
        end
      end
      b_edges[j] = cwin_nxt[pos] & !ok;
    end
  end

  assign b_emit       = b_flags_r[KERNEL_REACH-1] && (b_col_r >= AW'(KERNEL_REACH));
  assign q_load.valid = b_fire && b_emit;
  assign q_load.multi = b_last_r;

  always_ff @(posedge clk) begin
    if (b_fire) begin
      cwin_r <= cwin_nxt;
      vwin_r <= vwin_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result queue: hold the results and hand them out one per transaction.
  // --------------------------------------------------------------------------
  cti_result_queue #(
    .KERNEL_REACH (KERNEL_REACH)
  ) u_result_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (q_load),
    .load_edges (b_edges),
    .free       (q_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule : color_threshold_inner_edge
`default_nettype wire

@@ hdl/cti_result_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cti_result_queue
// Holds the results of one pixel and hands them out one per transaction.
// ----------------------------------------------------------------------------
module cti_result_queue #(
  parameter int KERNEL_REACH = cti_pkg::CTI_KERNEL_REACH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cti_pkg::cti_load_t load,
  input  wire logic [KERNEL_REACH:0] load_edges,
  output logic                    free,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output cti_pkg::cti_out_t       out_data
);
  import cti_pkg::*;

  localparam int IW = $clog2(KERNEL_REACH + 1);

  logic                  valid_r;
  logic                  multi_r;
  logic [KERNEL_REACH:0] edges_r;
  logic [IW-1:0]         idx_r;
  logic                  final_res;

  assign final_res = !multi_r || (idx_r == IW'(KERNEL_REACH));
  assign free      = !valid_r || (out_ready && final_res);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load.valid && free) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (valid_r && out_ready) begin
      if (final_res) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid && free) begin
      multi_r <= load.multi;
      edges_r <= load_edges;
    end
  end

  assign out_valid         = valid_r;
  assign out_data.edge_res = edges_r[idx_r];
  assign out_data.row_end  = multi_r && final_res;
  assign out_data.run_last = final_res;

endmodule : cti_result_queue
`default_nettype wire
